FILE: rtl/dsrt_pkg.sv
// dsrt_pkg: shared types, state codes and the packet builder for the speed refresh table
// used by dsrt_cell and dcc_speed_refresh_table_top; depends on nothing

package dsrt_pkg;

   localparam logic [7:0] LONG_MARK      = 8'hC0;
   localparam logic [7:0] SPEED128_INSTR = 8'h3F;
   localparam logic [13:0] SHORT_LIMIT   = 14'd127;
   localparam logic [6:0] SPEED_MAX      = 7'd126;
   localparam logic [2:0] LONG_COUNT     = 3'd4;
   localparam logic [2:0] SHORT_COUNT    = 3'd3;

   localparam logic FUNC_SET_SPEED = 1'b0;
   localparam logic FUNC_REFRESH   = 1'b1;

   typedef struct packed {
      logic        func;
      logic [13:0] loco_address;
      logic [6:0]  speed_step;
      logic        forward;
   } req_type;

   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [7:0] third_byte;
      logic [7:0] fourth_byte;
      logic [2:0] byte_count;
      logic       table_full;
   } rsp_type;

   typedef struct packed {
      logic [13:0] address;
      logic [6:0]  speed;
      logic        forward;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_EMIT
   } state_type;

   function automatic rsp_type build_packet(input logic [13:0] addr,
                                            input logic [6:0]  spd,
                                            input logic        fwd,
                                            input logic        full);
      rsp_type    pkt;
      logic [7:0] sb;
      sb = {fwd, spd + {6'd0, (spd != 7'd0)}};
      if (addr > SHORT_LIMIT) begin
         pkt.first_byte  = {2'b00, addr[13:8]} | LONG_MARK;
         pkt.second_byte = addr[7:0];
         pkt.third_byte  = SPEED128_INSTR;
         pkt.fourth_byte = sb;
         pkt.byte_count  = LONG_COUNT;
      end else begin
         pkt.first_byte  = addr[7:0];
         pkt.second_byte = SPEED128_INSTR;
         pkt.third_byte  = sb;
         pkt.fourth_byte = 8'd0;
         pkt.byte_count  = SHORT_COUNT;
      end
      pkt.table_full = full;
      return pkt;
   endfunction

endpackage

FILE: rtl/dsrt_cell.sv
// dsrt_cell: one table entry of the rotating ring, hands its entry to its neighbor on shift
// depends on dsrt_pkg (entry_type)

module dsrt_cell
   import dsrt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      shift_en,
   input  entry_type d_in,
   output entry_type q_out
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = shift_en ? d_in : entry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign q_out = entry_ff;

endmodule

FILE: rtl/dcc_speed_refresh_table_top.sv
// dcc_speed_refresh_table_top: locomotive speed table with 128-step packet builder
// depends on dsrt_pkg and dsrt_cell (ring of table entries)
//
//   channel   ports                                 moves
//   request   req_valid  req_ready  req_payload     req_type: command or refresh tick
//   result    rsp_valid  rsp_ready  rsp_payload     rsp_type: packet bytes, count, full flag
//
// the table is a ring of TABLE_ENTRIES cells rotating one place a cycle while scanning or
// writing; the entry at cell 0 (the head) is the one examined, a head counter tracks its index
// set speed: accept, a scan of every entry, a write that rotates to the target entry, then emit
// (table full skips the write); refresh: accept, scan and emit, but an empty table
// gives no packet and skips the emit; the emit cycle holds while the last result still waits
// one request at a time; a new request is taken while the last result still waits
// synchronous reset clears the ring, the pointer and the control state

module dcc_speed_refresh_table_top
   import dsrt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int IDXW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int PW   = $clog2(TABLE_ENTRIES + 1);
   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(TABLE_ENTRIES - 1);
   localparam logic [PW-1:0]   PTR_END  = PW'(TABLE_ENTRIES);

   // ring of cells
   entry_type cell_q [TABLE_ENTRIES];
   entry_type tail_in;
   logic      shift_en;

   for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_ring
      entry_type d_in;
      if (gi == TABLE_ENTRIES - 1) begin : g_tail
         assign d_in = tail_in;
      end else begin : g_link
         assign d_in = cell_q[gi+1];
      end
      dsrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .d_in     (d_in),
         .q_out    (cell_q[gi])
      );
   end

   // control state
   state_type       state_ff, state_in;
   logic [IDXW-1:0] head_ff, head_in;     // table index of the entry in cell 0
   logic [IDXW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0]   ptr_ff, ptr_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            match_found_ff, match_found_in;
   logic            empty_found_ff, empty_found_in;
   logic            hi_found_ff, hi_found_in;
   logic            any_found_ff, any_found_in;

   // payload state
   req_type         req_ff, req_in;
   rsp_type         pkt_ff, pkt_in;
   rsp_type         rsp_data_ff, rsp_data_in;
   logic [IDXW-1:0] match_idx_ff, match_idx_in;
   logic [IDXW-1:0] empty_idx_ff, empty_idx_in;
   logic [IDXW-1:0] slot_ff, slot_in;
   logic [IDXW-1:0] hi_idx_ff, hi_idx_in;
   logic [IDXW-1:0] any_idx_ff, any_idx_in;
   entry_type       hi_ent_ff, hi_ent_in;
   entry_type       any_ent_ff, any_ent_in;

   entry_type       head_ent;
   entry_type       new_ent;
   logic [PW-1:0]   scan_start;
   logic [PW-1:0]   head_wide;
   logic            occupied;
   logic            last_step;
   logic            rsp_free;

   assign head_ent   = cell_q[0];
   assign new_ent    = '{address: req_ff.loco_address,
                         speed:   req_ff.speed_step,
                         forward: req_ff.forward};
   // pointer at the end of the table means start from entry 0
   assign scan_start = (ptr_ff == PTR_END) ? '0 : ptr_ff;
   assign head_wide  = PW'(head_ff);
   assign occupied   = (head_ent.address != 14'd0);
   assign last_step  = (cnt_ff == LAST_IDX);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      cnt_in         = cnt_ff;
      ptr_in         = ptr_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      match_found_in = match_found_ff;
      empty_found_in = empty_found_ff;
      hi_found_in    = hi_found_ff;
      any_found_in   = any_found_ff;
      req_in         = req_ff;
      pkt_in         = pkt_ff;
      rsp_data_in    = rsp_data_ff;
      match_idx_in   = match_idx_ff;
      empty_idx_in   = empty_idx_ff;
      slot_in        = slot_ff;
      hi_idx_in      = hi_idx_ff;
      any_idx_in     = any_idx_ff;
      hi_ent_in      = hi_ent_ff;
      any_ent_in     = any_ent_ff;
      shift_en       = 1'b0;
      tail_in        = head_ent;
      req_ready      = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_payload;
               if (req_payload.speed_step > SPEED_MAX) begin
                  req_in.speed_step = SPEED_MAX;
               end
               match_found_in = 1'b0;
               empty_found_in = 1'b0;
               hi_found_in    = 1'b0;
               any_found_in   = 1'b0;
               cnt_in         = '0;
               state_in       = ST_SCAN;
            end
         end

         ST_SCAN: begin
            shift_en = 1'b1;
            head_in  = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            // lowest index wins since the scan starts mid-table
            if (head_ent.address == req_ff.loco_address &&
                (!match_found_ff || head_ff < match_idx_ff)) begin
               match_found_in = 1'b1;
               match_idx_in   = head_ff;
            end
            if (!occupied && (!empty_found_ff || head_ff < empty_idx_ff)) begin
               empty_found_in = 1'b1;
               empty_idx_in   = head_ff;
            end
            if (occupied && head_wide >= scan_start &&
                (!hi_found_ff || head_ff < hi_idx_ff)) begin
               hi_found_in = 1'b1;
               hi_idx_in   = head_ff;
               hi_ent_in   = head_ent;
            end
            if (occupied && (!any_found_ff || head_ff < any_idx_ff)) begin
               any_found_in = 1'b1;
               any_idx_in   = head_ff;
               any_ent_in   = head_ent;
            end
            if (last_step) begin
               // scan results include this cycle's head entry
               if (req_ff.func == FUNC_SET_SPEED) begin
                  if (match_found_in || empty_found_in) begin
                     slot_in  = match_found_in ? match_idx_in : empty_idx_in;
                     pkt_in   = build_packet(req_ff.loco_address, req_ff.speed_step,
                                             req_ff.forward, 1'b0);
                     state_in = ST_WRITE;
                  end else begin
                     pkt_in   = build_packet(req_ff.loco_address, req_ff.speed_step,
                                             req_ff.forward, 1'b1);
                     state_in = ST_EMIT;
                  end
               end else if (hi_found_in) begin
                  pkt_in   = build_packet(hi_ent_in.address, hi_ent_in.speed,
                                          hi_ent_in.forward, 1'b0);
                  ptr_in   = PW'(hi_idx_in) + 1'b1;
                  state_in = ST_EMIT;
               end else if (any_found_in) begin
                  pkt_in   = build_packet(any_ent_in.address, any_ent_in.speed,
                                          any_ent_in.forward, 1'b0);
                  ptr_in   = PW'(any_idx_in) + 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  // empty table: no packet
                  ptr_in   = PTR_END;
                  state_in = ST_IDLE;
               end
            end
         end

         ST_WRITE: begin
            // rotate until the target entry sits at the head, then replace it at the tail
            shift_en = 1'b1;
            head_in  = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
            if (head_ff == slot_ff) begin
               tail_in  = new_ent;
               ptr_in   = PW'(slot_ff);
               state_in = ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pkt_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         head_ff        <= '0;
         cnt_ff         <= '0;
         ptr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         match_found_ff <= 1'b0;
         empty_found_ff <= 1'b0;
         hi_found_ff    <= 1'b0;
         any_found_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         head_ff        <= head_in;
         cnt_ff         <= cnt_in;
         ptr_ff         <= ptr_in;
         rsp_valid_ff   <= rsp_valid_in;
         match_found_ff <= match_found_in;
         empty_found_ff <= empty_found_in;
         hi_found_ff    <= hi_found_in;
         any_found_ff   <= any_found_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      pkt_ff       <= pkt_in;
      rsp_data_ff  <= rsp_data_in;
      match_idx_ff <= match_idx_in;
      empty_idx_ff <= empty_idx_in;
      slot_ff      <= slot_in;
      hi_idx_ff    <= hi_idx_in;
      any_idx_ff   <= any_idx_in;
      hi_ent_ff    <= hi_ent_in;
      any_ent_ff   <= any_ent_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule
